@@ sv/bdt_pkg.sv @@
// Shared types and constants for the broadcast duplicate table
`timescale 1ns / 1ps
`default_nettype none
package bdt_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic {
    CFG_HOLD_TIME   = 1'b0,
    CFG_HALF_WINDOW = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_SCAN = 1'b1
  } bk_state_t;

  typedef struct packed {
    logic        insert;
    logic        in_range;
    logic [15:0] source_addr;
    logic [7:0]  seq_number;
    logic [31:0] now_time;
    logic [2:0]  slot_index;
  } cmd_t;

  typedef struct packed {
    logic [15:0] source_addr;
    logic [7:0]  seq_number;
    logic [31:0] expiry;
  } entry_t;

endpackage
`default_nettype wire

@@ sv/bdt_front.sv @@
// Input stage: accept words, unpack and classify them into commands
`timescale 1ns / 1ps
`default_nettype none
module bdt_front #(
  parameter int unsigned TABLE_ENTRIES = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [63:0]   in_tdata,
  input  wire logic          in_tuser,
  output logic               push_valid,
  input  wire logic          push_ready,
  output bdt_pkg::cmd_t      push_cmd
);
  import bdt_pkg::*;

  logic  vld_r;
  logic  vld_nxt;
  cmd_t  cmd_r;
  cmd_t  cmd_nxt;
  logic  accept;

  assign in_tready  = !vld_r || push_ready;
  assign accept     = in_tvalid && in_tready;
  assign push_valid = vld_r;
  assign push_cmd   = cmd_r;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (push_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_comb begin
    cmd_nxt             = cmd_r;
    if (accept) begin
      cmd_nxt.insert      = in_tuser;
      cmd_nxt.source_addr = in_tdata[15:0];
      cmd_nxt.seq_number  = in_tdata[23:16];
      cmd_nxt.now_time    = in_tdata[55:24];
      cmd_nxt.slot_index  = in_tdata[58:56];
      cmd_nxt.in_range    = {5'b0, in_tdata[58:56]} < 8'(TABLE_ENTRIES);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

endmodule
`default_nettype wire

@@ sv/bdt_queue.sv @@
// Two-entry command queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module bdt_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire bdt_pkg::cmd_t  push_cmd,
  output logic                pop_valid,
  input  wire logic           pop,
  output bdt_pkg::cmd_t       pop_cmd
);
  import bdt_pkg::*;

  cmd_t       slots_r [QUEUE_DEPTH];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       do_push;
  logic       do_pop;

  assign push_ready = count_r != 2'(QUEUE_DEPTH);
  assign pop_valid  = count_r != 2'd0;
  assign pop_cmd    = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

@@ sv/bdt_back.sv @@
// Table store and scan engine: inserts records and scans one entry per cycle
`timescale 1ns / 1ps
`default_nettype none
module bdt_back #(
  parameter int unsigned TABLE_ENTRIES = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [31:0]    hold_time,
  input  wire logic [31:0]    half_window,
  input  wire logic           q_valid,
  input  wire bdt_pkg::cmd_t  q_cmd,
  output logic                q_pop,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output bdt_pkg::status_t    out_status,
  output logic [3:0]          out_found
);
  import bdt_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] NONE_IDX = CNT_W'(TABLE_ENTRIES);

  entry_t               mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] used_r;
  entry_t               rd_data_r;
  logic                 used_q_r;

  bk_state_t            state_r;
  bk_state_t            state_nxt;
  cmd_t                 cmd_r;
  logic [IDX_W-1:0]     eval_idx_r;
  logic [IDX_W-1:0]     eval_idx_nxt;
  logic [CNT_W-1:0]     found_r;
  logic [CNT_W-1:0]     found_nxt;
  logic                 out_vld_r;
  status_t              status_r;
  status_t              status_nxt;
  logic [3:0]           out_found_r;
  logic [3:0]           out_found_nxt;

  logic                 load_cmd;
  logic                 mem_we;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     wr_addr;
  logic [IDX_W+2:0]     slot_wide;
  entry_t               wr_entry;
  logic                 res_load;
  logic                 out_free;
  logic                 cand;
  logic                 match;
  logic                 last;
  logic                 dup_hit;
  logic                 scan_done;
  logic [CNT_W-1:0]     found_upd;
  logic [CNT_W+3:0]     found_wide;

  assign out_free   = !out_vld_r || out_tready;
  assign cand       = !used_q_r || ((cmd_r.now_time - rd_data_r.expiry) < half_window);
  assign match      = (rd_data_r.source_addr == cmd_r.source_addr) &&
                      (rd_data_r.seq_number == cmd_r.seq_number);
  assign last       = eval_idx_r == LAST_IDX;
  assign dup_hit    = !cand && match;
  assign scan_done  = dup_hit || last;
  assign found_upd  = cand ? CNT_W'(eval_idx_r) : found_r;
  assign found_wide = {4'b0, found_upd};

  assign slot_wide  = {IDX_W'(0), q_cmd.slot_index};
  assign wr_addr    = slot_wide[IDX_W-1:0];
  assign wr_entry   = '{source_addr: q_cmd.source_addr,
                        seq_number:  q_cmd.seq_number,
                        expiry:      q_cmd.now_time + hold_time};

  assign out_tvalid = out_vld_r;
  assign out_status = status_r;
  assign out_found  = out_found_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid && !q_cmd.insert) begin
          state_nxt = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (scan_done && out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop         = 1'b0;
    load_cmd      = 1'b0;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    eval_idx_nxt  = eval_idx_r;
    found_nxt     = found_r;
    res_load      = 1'b0;
    status_nxt    = status_r;
    out_found_nxt = out_found_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          if (q_cmd.insert) begin
            if (out_free) begin
              q_pop         = 1'b1;
              mem_we        = q_cmd.in_range;
              res_load      = 1'b1;
              status_nxt    = ST_OK;
              out_found_nxt = {1'b0, q_cmd.slot_index};
            end
          end else begin
            q_pop        = 1'b1;
            load_cmd     = 1'b1;
            rd_en        = 1'b1;
            eval_idx_nxt = '0;
            found_nxt    = NONE_IDX;
          end
        end
      end
      BK_SCAN: begin
        if (scan_done) begin
          if (out_free) begin
            found_nxt     = found_upd;
            res_load      = 1'b1;
            out_found_nxt = found_wide[3:0];
            if (dup_hit) begin
              status_nxt = ST_DUPLICATE;
            end else if (found_upd == NONE_IDX) begin
              status_nxt = ST_FULL;
            end else begin
              status_nxt = ST_OK;
            end
          end
        end else begin
          found_nxt    = found_upd;
          eval_idx_nxt = eval_idx_r + 1'b1;
          rd_en        = 1'b1;
          rd_addr      = eval_idx_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      out_vld_r <= 1'b0;
      used_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (res_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (mem_we) begin
        used_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      used_q_r  <= used_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (load_cmd) begin
      cmd_r <= q_cmd;
    end
    eval_idx_r  <= eval_idx_nxt;
    found_r     <= found_nxt;
    status_r    <= status_nxt;
    out_found_r <= out_found_nxt;
  end

endmodule
`default_nettype wire

@@ sv/broadcast_duplicate_table.sv @@
// Broadcast duplicate-rejection table, top level
//
// Input stream: one word per frame; in_tuser selects check (0) or insert (1).
// Result stream: one word per input word, in order, with status in out_tuser.
// Configuration: cfg_we writes hold_time (index 0) or half_window (index 1)
// from cfg_wdata; write only while no word is in flight.
// A front register unpacks and classifies the word into a two-entry command
// queue; the back end owns the table memory and the result register.
// An insert passes the front register and the queue into the result register;
// a check also scans the table, and a duplicate stops the scan early.
// The back end handles one word at a time; a check is limited by the single
// table read port, which scans one entry per cycle.
// Reset clears all used flags and loads hold_time = 1000000 and
// half_window = 2^31; record fields need no clearing pass.
// A stalled receiver holds the result; the back end finishes its current
// scan and waits, while the front and queue keep taking up to three words.
`timescale 1ns / 1ps
`default_nettype none
module broadcast_duplicate_table #(
  parameter int unsigned TABLE_ENTRIES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // source_addr[15:0], seq_number[23:16],
                                       // now_time[55:24], slot_index[58:56]
  input  wire logic        in_tuser,   // mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // found_slot[3:0]
  output logic [1:0]       out_tuser,  // status
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  import bdt_pkg::*;

  logic [31:0] hold_time_r;
  logic [31:0] half_window_r;
  logic        q_push;
  logic        q_ready;
  cmd_t        push_cmd;
  logic        q_valid;
  logic        q_pop;
  cmd_t        q_cmd;
  status_t     status;
  logic [3:0]  found_slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_time_r   <= 32'd1000000;
      half_window_r <= 32'h8000_0000;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_HOLD_TIME:   hold_time_r   <= cfg_wdata;
        CFG_HALF_WINDOW: half_window_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bdt_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (q_push),
    .push_ready (q_ready),
    .push_cmd   (push_cmd)
  );

  bdt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push),
    .push_ready (q_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  bdt_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .hold_time   (hold_time_r),
    .half_window (half_window_r),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_status  (status),
    .out_found   (found_slot)
  );

  assign out_tdata = {4'b0, found_slot};
  assign out_tuser = status;

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("back end popped an empty queue");

  a_front_holds_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_ready) |=> q_push)
    else $error("front dropped a command while the queue was full");

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule
`default_nettype wire

@@ tb/bdt_verdict_checker.sv @@
// Checker for the broadcast duplicate table: predicts each verdict and compares results
`timescale 1ns / 1ps
module bdt_verdict_checker #(
  parameter int unsigned TABLE_ENTRIES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // source_addr[15:0], seq_number[23:16],
                                  // now_time[55:24], slot_index[58:56]
  input  logic        in_tuser,   // mode
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // found_slot[3:0]
  input  logic [1:0]  out_tuser,  // status
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          verdicts_seen,
  output int          dups_seen,
  output int          fulls_seen
);
  import bdt_pkg::*;

  typedef struct packed {
    status_t    status;
    logic [3:0] slot;
  } verdict_t;

  logic        rec_used   [TABLE_ENTRIES];
  logic [15:0] rec_source [TABLE_ENTRIES];
  logic [7:0]  rec_seq    [TABLE_ENTRIES];
  logic [31:0] rec_expiry [TABLE_ENTRIES];
  logic [31:0] hold_ticks;
  logic [31:0] window;
  verdict_t    verdict_q[$];
  int          errors;
  int          n_seen;
  int          n_dup;
  int          n_full;

  function automatic verdict_t scan_verdict(input logic [15:0] src, input logic [7:0] seq,
                                            input logic [31:0] now);
    verdict_t    v;
    logic [31:0] elapsed;
    v.status = ST_OK;
    v.slot = 4'(TABLE_ENTRIES);
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      elapsed = now - rec_expiry[k];
      if (!rec_used[k] || elapsed < window) begin
        v.slot = 4'(k);
      end else if (rec_source[k] == src && rec_seq[k] == seq) begin
        v.status = ST_DUPLICATE;
        break;
      end
    end
    if (v.status == ST_OK && v.slot == 4'(TABLE_ENTRIES))
      v.status = ST_FULL;
    return v;
  endfunction

  always @(posedge clk) begin : watch
    verdict_t    want;
    logic [2:0]  slot;
    logic [15:0] src;
    logic [7:0]  seq;
    logic [31:0] now;
    if (!rst_n) begin
      for (int k = 0; k < TABLE_ENTRIES; k++) rec_used[k] = 1'b0;
      hold_ticks = 32'd1000000;
      window = 32'h8000_0000;
      verdict_q.delete();
      errors = 0;
      n_seen = 0;
      n_dup = 0;
      n_full = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_HOLD_TIME:   hold_ticks = cfg_wdata;
          CFG_HALF_WINDOW: window = cfg_wdata;
        endcase
      end
      if (in_tvalid && in_tready) begin
        src = in_tdata[15:0];
        seq = in_tdata[23:16];
        now = in_tdata[55:24];
        slot = in_tdata[58:56];
        if (in_tuser) begin
          if (slot < TABLE_ENTRIES) begin
            rec_used[slot] = 1'b1;
            rec_source[slot] = src;
            rec_seq[slot] = seq;
            rec_expiry[slot] = now + hold_ticks;
          end
          want.status = ST_OK;
          want.slot = {1'b0, slot};
        end else begin
          want = scan_verdict(src, seq, now);
        end
        verdict_q.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, status %0d found_slot %0d", $time,
                   out_tuser, out_tdata);
        end else begin
          want = verdict_q.pop_front();
          n_seen++;
          if (want.status == ST_DUPLICATE) n_dup++;
          if (want.status == ST_FULL) n_full++;
          if (out_tuser !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                     want.status, out_tuser);
          end
          if (out_tdata !== {4'd0, want.slot}) begin
            errors++;
            $display("%0t: found_slot mismatch, expected %0d, actual %0d", $time,
                     want.slot, out_tdata);
          end
        end
      end
    end
    fail_count <= errors;
    pending <= verdict_q.size();
    verdicts_seen <= n_seen;
    dups_seen <= n_dup;
    fulls_seen <= n_full;
  end

endmodule

@@ tb/tb_broadcast_duplicate_table.sv @@
// Testbench top for the broadcast duplicate table: stimulus, flow control and verdict
`timescale 1ns / 1ps
module tb_broadcast_duplicate_table;
  import bdt_pkg::*;

  localparam int unsigned ENTRIES = 8;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_WORDS = 235;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // source_addr[15:0], seq_number[23:16],
                                // now_time[55:24], slot_index[58:56]
  logic        in_tuser = 1'b0; // mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // found_slot[3:0]
  logic [1:0]  out_tuser;       // status
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_wdata = '0;

  int fail_count;
  int pending;
  int verdicts_seen;
  int dups_seen;
  int fulls_seen;
  int cycle_count = 0;
  int words_sent = 0;
  int settings_run = 1;
  int unsigned send_calm = 0;
  int unsigned recv_calm = 0;

  logic [31:0] clock_now = 32'd0;
  logic        aim_set [ENTRIES];
  logic [15:0] aim_src [ENTRIES];
  logic [7:0]  aim_seq [ENTRIES];
  logic [31:0] aim_exp [ENTRIES];

  logic [31:0] hold_tab [7] = '{32'd1000, 32'hFFFF_FFFF, 32'd1, 32'd50,
                                32'h8000_0000, 32'd20000, 32'd1000000};
  logic [31:0] win_tab  [7] = '{32'h8000_0000, 32'hFFFF_FFFF, 32'd1, 32'd0,
                                32'h8000_0000, 32'h0001_0000, 32'd1};

  broadcast_duplicate_table #(.TABLE_ENTRIES(ENTRIES)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  bdt_verdict_checker #(.TABLE_ENTRIES(ENTRIES)) u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .verdicts_seen (verdicts_seen),
    .dups_seen     (dups_seen),
    .fulls_seen    (fulls_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int unsigned draw_wait(inout int unsigned calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  task automatic send_word(input logic mode, input logic [15:0] src, input logic [7:0] seq,
                           input logic [31:0] now, input logic [2:0] slot);
    int unsigned gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {5'd0, slot, now, seq, src};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  // hold off until every result is back, then let the scan pipeline settle
  task automatic drain(input int settle);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] hold, input logic [31:0] win);
    cfg_we <= 1'b1;
    cfg_index <= CFG_HOLD_TIME;
    cfg_wdata <= hold;
    @(posedge clk);
    cfg_index <= CFG_HALF_WINDOW;
    cfg_wdata <= win;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  task automatic random_words(input logic [31:0] hold, input logic [31:0] win,
                              input int count);
    int unsigned pick;
    int unsigned k;
    logic        mode;
    logic [15:0] src;
    logic [7:0]  seq;
    logic [31:0] now;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, ENTRIES - 1);
      clock_now = clock_now + $urandom_range(0, (hold >> 3) + 1);
      mode = 1'b0;
      src = 16'($urandom);
      seq = 8'($urandom);
      now = clock_now;
      if (pick < 30) begin
        mode = 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          src = aim_src[$urandom_range(0, ENTRIES - 1)];
          seq = aim_seq[$urandom_range(0, ENTRIES - 1)];
        end
        aim_set[k] = 1'b1;
        aim_src[k] = src;
        aim_seq[k] = seq;
        aim_exp[k] = now + hold;
      end else if (aim_set[k] && pick < 66) begin
        src = aim_src[k];
        seq = aim_seq[k];
      end else if (aim_set[k] && pick < 76) begin
        src = aim_src[k];
        seq = aim_seq[k];
        if ($urandom_range(0, 1))
          seq = seq ^ (8'd1 << $urandom_range(0, 7));
        else
          src = src ^ (16'd1 << $urandom_range(0, 15));
      end else if (aim_set[k] && pick < 86) begin
        src = aim_src[k];
        seq = aim_seq[k];
        now = aim_exp[k] + $urandom_range(0, 4) - 32'd2;
      end else if (aim_set[k] && pick < 92) begin
        src = aim_src[k];
        seq = aim_seq[k];
        now = aim_exp[k] + win + $urandom_range(0, 2) - 32'd1;
      end else if (pick < 96) begin
        now = $urandom;
      end else if (pick < 98) begin
        clock_now = $urandom;
        now = clock_now;
      end
      send_word(mode, src, seq, now, k[2:0]);
    end
  endtask

  initial begin : receiver
    int unsigned stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin : stimulus
    for (int k = 0; k < ENTRIES; k++) begin
      aim_set[k] = 1'b0;
      aim_src[k] = 16'd0;
      aim_seq[k] = 8'd0;
      aim_exp[k] = 32'd0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_word(1'b0, 16'h0000, 8'h00, 32'h0000_0000, 3'd0);
    send_word(1'b1, 16'h0000, 8'h00, 32'hFFFF_FF00, 3'd0);
    send_word(1'b1, 16'hFFFF, 8'hFF, 32'hFFFF_FF00, 3'd1);
    send_word(1'b1, 16'hAAAA, 8'hAA, 32'hFFFF_FF00, 3'd2);
    send_word(1'b1, 16'h5555, 8'h55, 32'hFFFF_FF00, 3'd3);
    send_word(1'b1, 16'h0000, 8'hFF, 32'hFFFF_FF00, 3'd4);
    send_word(1'b1, 16'hFFFF, 8'h00, 32'hFFFF_FF00, 3'd5);
    send_word(1'b1, 16'h1234, 8'h7E, 32'hFFFF_FF00, 3'd6);
    send_word(1'b1, 16'h8001, 8'h81, 32'hFFFF_FFFF, 3'd7);
    send_word(1'b0, 16'hFFFF, 8'hFF, 32'hFFFF_FF10, 3'd7);
    send_word(1'b0, 16'h1234, 8'h7E, 32'h0000_0100, 3'd0);
    send_word(1'b0, 16'h0000, 8'h55, 32'h0000_0200, 3'd5);
    send_word(1'b0, 16'h8001, 8'h80, 32'h0000_0300, 3'd2);
    send_word(1'b0, 16'h5555, 8'h55, 32'h000F_4140, 3'd0);
    send_word(1'b1, 16'h4321, 8'h10, 32'h000F_4140, 3'd5);
    send_word(1'b0, 16'h4321, 8'h10, 32'h000F_4141, 3'd3);
    send_word(1'b0, 16'h4321, 8'h11, 32'h000F_4141, 3'd6);
    send_word(1'b0, 16'h4321, 8'h10, 32'hFFFF_FFFF, 3'd1);
    send_word(1'b0, 16'h8001, 8'h81, 32'h000F_413F, 3'd4);
    send_word(1'b0, 16'h8001, 8'h81, 32'h800F_4140, 3'd4);

    random_words(32'd1000000, 32'h8000_0000, PHASE_WORDS);
    drain(4);
    for (int p = 0; p < 7; p++) begin
      set_config(hold_tab[p], win_tab[p]);
      random_words(hold_tab[p], win_tab[p], PHASE_WORDS);
      drain(4);
    end

    drain(2 * ENTRIES + 8);
    $display("Summary: %0d words sent under %0d table settings, %0d results checked",
             words_sent, settings_run, verdicts_seen);
    $display("Summary: %0d duplicate and %0d full verdicts among them", dups_seen, fulls_seen);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
